// File: rtl/core/mewd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mewd_pkg;

	typedef enum logic [3:0] {
		M_LIT     = 4'd0,
		M_LIT_EQ  = 4'd1,
		M_CHARSET = 4'd2,
		M_ENC     = 4'd3,
		M_Q_HDR   = 4'd4,
		M_Q_TXT   = 4'd5,
		M_Q_EQ    = 4'd6,
		M_Q_EQ1   = 4'd7,
		M_B_HDR   = 4'd8,
		M_B_TXT   = 4'd9,
		M_B_SKIP  = 4'd10,
		M_POST    = 4'd11
	} mode_t;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_QM = 8'h3F;
	localparam logic [7:0] CH_LOWER_Q = 8'h71;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam int ADDR_W = 3;
	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic [15:0] MAX_LEN_RST = 16'd1023;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic hex_ok(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [3:0] v;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = b[3:0];
		end else begin
			v = b[3:0] + 4'd9;
		end
		return v;
	endfunction

	function automatic logic sextet_ok(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
			(b >= 8'h30 && b <= 8'h39) || b == 8'h2B || b == 8'h2F;
	endfunction

	// Base64 alphabet A-Z a-z 0-9 + /
	function automatic logic [5:0] sextet_val(input logic [7:0] b);
		logic [7:0] v;
		if (b >= 8'h41 && b <= 8'h5A) begin
			v = b - 8'h41;
		end else if (b >= 8'h61 && b <= 8'h7A) begin
			v = b - 8'd71;
		end else if (b >= 8'h30 && b <= 8'h39) begin
			v = b + 8'd4;
		end else if (b == 8'h2B) begin
			v = 8'd62;
		end else begin
			v = 8'd63;
		end
		return v[5:0];
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/mewd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mewd_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source(output valid, output in_byte, output end_of_text, input ready);
	modport sink(input valid, input in_byte, input end_of_text, output ready);
endinterface

interface mewd_dec_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;

	modport source(output valid, output out_byte, output run_end, input ready);
	modport sink(input valid, input out_byte, input run_end, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mime_encoded_word_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming decoder for MIME encoded words in header text.
// raw: one header byte per item, end_of_text on the final byte of a text.
// dec: decoded bytes, zero to two per raw item; run_end marks the last
//   result produced by a raw item.
// Config (APB): max_len at byte address 0, limit on decoded bytes per text;
//   reset value 1023. Write it only while the block is idle.
// Path: a raw item is registered in the input register at acceptance, decoded
//   combinationally from that register and written into a four-entry result
//   queue once the queue has room; dec is driven from the queue head.
// Throughput: one raw item per cycle while each item yields at most one
//   result and dec is ready; the result queue drains one item per cycle while
//   dec is ready, so a run of items producing two results fills the queue.
// A stalled dec side fills the queue; raw.ready drops while an item waits in
//   the input register and fewer than two queue slots are free, and nothing
//   is lost.
// Reset clears the parser to literal mode, empties the queue and restores
//   max_len.
module mime_encoded_word_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mewd_raw_if.sink                           raw,
	mewd_dec_if.source                         dec,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mewd_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import mewd_pkg::*;

	logic [15:0] max_len_q;
	logic        room2;
	push_t       push;
	res_t        out_item;
	logic        out_valid;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'd0, max_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN) begin
			max_len_q <= pwdata[15:0];
		end
	end

	mewd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (raw.valid),
		.in_ready    (raw.ready),
		.in_byte     (raw.in_byte),
		.end_of_text (raw.end_of_text),
		.max_len     (max_len_q),
		.room2       (room2),
		.push        (push)
	);

	mewd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (dec.ready),
		.out_item  (out_item)
	);

	assign dec.valid    = out_valid;
	assign dec.out_byte = out_item.out_byte;
	assign dec.run_end  = out_item.run_end;
endmodule
`default_nettype wire

// File: rtl/core/mewd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module mewd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mewd_pkg::push_t push,
	output logic                room2,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mewd_pkg::res_t      out_item
);
	import mewd_pkg::*;

	res_t       mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] count_q;
	logic       pop;

	assign out_valid = count_q != 3'd0;
	assign out_item  = mem_q[rp_q];
	assign pop       = out_valid && out_ready;
	assign room2     = count_q <= 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 2'd0;
			rp_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wp_q    <= wp_q + push.n;
			rp_q    <= rp_q + {1'b0, pop};
			count_q <= 3'(count_q + {1'b0, push.n} - {2'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + 2'd1] <= push.r1;
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4) else $error("result queue overfilled");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room2) else $error("push without room");
	a_pop_track: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.n == 2'd0 |=> count_q == $past(count_q) - 3'd1)
		else $error("pop lost");
endmodule
`default_nettype wire

// File: rtl/core/mewd_core.sv
`timescale 1ns / 1ps
`default_nettype none
module mewd_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_byte,
	input  wire logic            end_of_text,
	input  wire logic [15:0]     max_len,
	input  wire logic            room2,
	output mewd_pkg::push_t      push
);
	import mewd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;

	mode_t      mode_q, nmode;
	logic [7:0] held_q, nheld;
	logic [1:0] phase_q, nphase;
	logic [7:0] part_q, npart;
	logic [15:0] cnt_q, ncnt;

	logic       c1v, c2v, c3v;
	logic [7:0] c1b, c2b, c3b;
	logic [7:0] first_b, second_b;
	logic [1:0] n_att, nemit;
	logic       ok1, ok2;
	logic [5:0] sx;
	logic [7:0] b;

	assign adv      = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_LIT;
			held_q  <= 8'd0;
			phase_q <= 2'd0;
			part_q  <= 8'd0;
			cnt_q   <= 16'd0;
		end else if (adv) begin
			mode_q  <= nmode;
			held_q  <= nheld;
			phase_q <= nphase;
			part_q  <= npart;
			cnt_q   <= ncnt;
		end
	end

	always_comb begin
		b      = byte_s1;
		sx     = sextet_val(byte_s1);
		nmode  = mode_q;
		nheld  = held_q;
		nphase = phase_q;
		npart  = part_q;
		c1v = 1'b0; c1b = byte_s1;
		c2v = 1'b0; c2b = byte_s1;
		c3v = 1'b0; c3b = 8'd0;

		case (mode_q)
			M_LIT_EQ: begin
				if (b == CH_QM) begin
					nmode = M_CHARSET;
				end else begin
					// release the held '=' and take the byte as literal, or hold it if it is another '='
					c1v   = 1'b1;
					c1b   = CH_EQ;
					nmode = M_LIT;
					if (b == CH_EQ) begin
						nheld = b;
						nmode = M_LIT_EQ;
					end else begin
						c2v = 1'b1;
					end
				end
			end
			M_CHARSET: begin
				if (b == CH_QM) nmode = M_ENC;
			end
			M_ENC: begin
				if ((b | CASE_BIT) == CH_LOWER_Q) begin
					nmode = M_Q_HDR;
				end else if ((b | CASE_BIT) == CH_LOWER_B) begin
					nmode = M_B_HDR;
				end else begin
					nmode = M_POST;
				end
			end
			M_Q_HDR: begin
				if (b == CH_QM) nmode = M_Q_TXT;
			end
			M_Q_TXT: begin
				nmode = M_Q_TXT;
				if (b == CH_QM) nmode = M_POST;
				else if (b == CH_EQ) nmode = M_Q_EQ;
				else c1v = 1'b1;
			end
			M_Q_EQ: begin
				if (hex_ok(b)) begin
					nheld = b;
					nmode = M_Q_EQ1;
				end else begin
					nmode = M_Q_TXT;
					if (b == CH_QM) nmode = M_POST;
					else if (b == CH_EQ) nmode = M_Q_EQ;
					else c1v = 1'b1;
				end
			end
			M_Q_EQ1: begin
				c1v = 1'b1;
				if (hex_ok(b)) begin
					c1b   = {hex_val(held_q), hex_val(b)};
					nmode = M_Q_TXT;
				end else begin
					// bad escape: emit the first digit, then handle the byte as text
					c1b   = held_q;
					nmode = M_Q_TXT;
					if (b == CH_QM) nmode = M_POST;
					else if (b == CH_EQ) nmode = M_Q_EQ;
					else c2v = 1'b1;
				end
			end
			M_B_HDR: begin
				if (b == CH_QM) begin
					nmode  = M_B_TXT;
					nphase = 2'd0;
					npart  = 8'd0;
				end
			end
			M_B_TXT: begin
				if (!is_ws(b)) begin
					if (b == CH_EQ) begin
						nmode = M_B_SKIP;
					end else if (!sextet_ok(b)) begin
						nmode = M_POST;
					end else begin
						case (phase_q)
							2'd0: begin
								npart  = {sx, 2'b00};
								nphase = 2'd1;
							end
							2'd1: begin
								c1v    = 1'b1;
								c1b    = part_q | {6'd0, sx[5:4]};
								npart  = {sx[3:0], 4'd0};
								nphase = 2'd2;
							end
							2'd2: begin
								c1v    = 1'b1;
								c1b    = part_q | {4'd0, sx[5:2]};
								npart  = {sx[1:0], 6'd0};
								nphase = 2'd3;
							end
							default: begin
								c1v    = 1'b1;
								c1b    = part_q | {2'd0, sx};
								npart  = 8'd0;
								nphase = 2'd0;
							end
						endcase
					end
				end
			end
			M_B_SKIP: begin
				if (b == CH_QM) nmode = M_POST;
			end
			M_POST: begin
				// drop one '=' after the closing '?' or an invalid byte; pass any other byte as literal
				nmode = M_LIT;
				if (b != CH_EQ) begin
					c1v = 1'b1;
					if (b == CH_EQ) c1v = 1'b0;
				end
			end
			default: begin
				nmode = M_LIT;
				if (b == CH_EQ) begin
					nheld = b;
					nmode = M_LIT_EQ;
				end else begin
					c1v = 1'b1;
				end
			end
		endcase

		if (last_s1) begin
			if (nmode == M_LIT_EQ) begin
				c3v = 1'b1;
				c3b = nheld;
			end
			nmode  = M_LIT;
			nheld  = 8'd0;
			nphase = 2'd0;
			npart  = 8'd0;
		end

		// pack the attempts; at most two occur per item
		first_b  = c1v ? c1b : (c2v ? c2b : c3b);
		second_b = (c1v && c2v) ? c2b : c3b;
		n_att    = 2'({1'b0, c1v} + {1'b0, c2v} + {1'b0, c3v});

		ok1 = {1'b0, cnt_q} < {1'b0, max_len};
		ok2 = ({1'b0, cnt_q} + 17'd1) < {1'b0, max_len};
		case (n_att)
			2'd0:    nemit = 2'd0;
			2'd1:    nemit = ok1 ? 2'd1 : 2'd0;
			default: nemit = ok2 ? 2'd2 : (ok1 ? 2'd1 : 2'd0);
		endcase

		ncnt = last_s1 ? 16'd0 : cnt_q + {14'd0, nemit};

		push.n           = adv ? nemit : 2'd0;
		push.r0.out_byte = first_b;
		push.r0.run_end  = nemit == 2'd1;
		push.r1.out_byte = second_b;
		push.r1.run_end  = 1'b1;
	end

	a_text_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> cnt_q == 16'd0 && mode_q == M_LIT && phase_q == 2'd0)
		else $error("state not cleared at end of text");
	a_pair_mark: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> !push.r0.run_end && push.r1.run_end)
		else $error("run_end misplaced in pair");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !last_s1 |=> cnt_q - $past(cnt_q) <= 16'd2)
		else $error("emitted count jumped");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room2 |=> valid_s1 && byte_s1 == $past(byte_s1))
		else $error("stalled item lost");
endmodule
`default_nettype wire
